@@ sv/utf8c_pkg.sv @@
// shared types and constants for the utf-8 canonical text checker
`timescale 1ns / 1ps

package utf8c_pkg;

  localparam int unsigned CP_W    = 21;
  localparam int unsigned LEN_W   = 32;
  localparam int unsigned COUNT_W = LEN_W + 1;

  localparam logic [7:0] LEAD2_LO = 8'hc2;
  localparam logic [7:0] LEAD2_HI = 8'hdf;
  localparam logic [7:0] LEAD3_LO = 8'he0;
  localparam logic [7:0] LEAD3_HI = 8'hef;
  localparam logic [7:0] LEAD4_LO = 8'hf0;
  localparam logic [7:0] LEAD4_HI = 8'hf4;

  localparam logic [CP_W-1:0] CP_ASCII_END = 21'h000080;
  localparam logic [CP_W-1:0] CP_TWO_END   = 21'h000800;
  localparam logic [CP_W-1:0] CP_THREE_END = 21'h010000;
  localparam logic [CP_W-1:0] CP_MAX       = 21'h10ffff;
  localparam logic [CP_W-1:0] CP_SURR_LO   = 21'h00d800;
  localparam logic [CP_W-1:0] CP_SURR_HI   = 21'h00dfff;
  localparam logic [CP_W-1:0] CP_COMB_LO   = 21'h000300;
  localparam logic [CP_W-1:0] CP_COMB_HI   = 21'h00036f;

  localparam logic [COUNT_W-1:0] COUNT_SAT = {1'b1, {LEN_W{1'b0}}};

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_NONCANON = 2'd1,
    STATUS_TOO_LONG = 2'd2
  } utf8c_status_t;

  typedef struct packed {
    logic [1:0]      pending;
    logic [1:0]      lead_len;
    logic [CP_W-1:0] cp;
    logic            err;
  } utf8c_state_t;

endpackage

@@ sv/utf8c_decode.sv @@
// byte decoder: next decode state from the current state and one text byte
`timescale 1ns / 1ps

module utf8c_decode
  import utf8c_pkg::*;
(
  input  utf8c_state_t state_cur,
  input  logic [7:0]   data_byte,
  input  logic         has_byte,
  output utf8c_state_t state_next
);

  logic [CP_W-1:0] cp_shift;
  logic [1:0]      pending_dec;
  logic            cp_bad;

  assign cp_shift    = {state_cur.cp[CP_W-7:0], data_byte[5:0]};
  assign pending_dec = state_cur.pending - 2'd1;

  always_comb begin
    cp_bad = (cp_shift < CP_ASCII_END) ||
             ((cp_shift < CP_TWO_END) && (state_cur.lead_len >= 2'd2)) ||
             ((cp_shift < CP_THREE_END) && (state_cur.lead_len == 2'd3)) ||
             (cp_shift > CP_MAX) ||
             ((cp_shift >= CP_SURR_LO) && (cp_shift <= CP_SURR_HI)) ||
             ((cp_shift >= CP_COMB_LO) && (cp_shift <= CP_COMB_HI));
  end

  always_comb begin
    state_next = state_cur;
    if (has_byte && !state_cur.err) begin
      if (state_cur.pending == 2'd0) begin
        if (data_byte[7] == 1'b0) begin
          state_next = state_cur;
        end else if (data_byte >= LEAD2_LO && data_byte <= LEAD2_HI) begin
          state_next.cp       = {{(CP_W-5){1'b0}}, data_byte[4:0]};
          state_next.lead_len = 2'd1;
          state_next.pending  = 2'd1;
        end else if (data_byte >= LEAD3_LO && data_byte <= LEAD3_HI) begin
          state_next.cp       = {{(CP_W-4){1'b0}}, data_byte[3:0]};
          state_next.lead_len = 2'd2;
          state_next.pending  = 2'd2;
        end else if (data_byte >= LEAD4_LO && data_byte <= LEAD4_HI) begin
          state_next.cp       = {{(CP_W-3){1'b0}}, data_byte[2:0]};
          state_next.lead_len = 2'd3;
          state_next.pending  = 2'd3;
        end else begin
          state_next.err = 1'b1;
        end
      end else if (data_byte[7:6] != 2'b10) begin
        state_next.err = 1'b1;
      end else begin
        state_next.cp      = cp_shift;
        state_next.pending = pending_dec;
        if (pending_dec == 2'd0 && cp_bad) begin
          state_next.err = 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/utf8_canonical_text_checker.sv @@
// top level: utf-8 canonical text checker with length limit
`timescale 1ns / 1ps

// usage
//   input channel: in_valid / in_stall carry one text byte per item
//   (in_data_byte with in_has_byte set); in_last closes the text, and an
//   item with in_has_byte low and in_last high ends the text without a byte
//   output channel: out_valid / out_stall carry one verdict per text,
//   out_status 0 canonical, 1 non-canonical, 2 longer than cfg max length
//   config: cfg_wr_en writes cfg_wr_data into the max length register; the
//   user writes it only while no text is in flight; the block does not check
//   order: an accepted item sits in the input register; its decode goes to
//   the text state register and, for a last item, its verdict to the verdict
//   register; a last item waits there while a stalled verdict blocks the output
//   throughput: one item per cycle unless stalled, set by the single decode
//   step between the input register and the text state / verdict register
//   stall: a stalled verdict holds; items that produce no verdict keep
//   flowing, and the input stalls only when a last item meets a full output
//   reset: decode state and byte count clear, max length goes to all ones

module utf8_canonical_text_checker
  import utf8c_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_has_byte,
  input  logic             in_last,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  logic               s1_valid_r;
  logic [7:0]         s1_byte_r;
  logic               s1_has_r;
  logic               s1_last_r;
  logic               s1_adv;

  utf8c_state_t       state_r;
  utf8c_state_t       state_nxt;
  utf8c_state_t       state_dec;
  logic [COUNT_W-1:0] count_r;
  logic [COUNT_W-1:0] count_nxt;
  logic [LEN_W-1:0]   max_len_r;

  logic               out_valid_r;
  utf8c_status_t      status_r;
  utf8c_status_t      status_nxt;
  logic               out_free;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_adv;

  utf8c_decode u_decode (
    .state_cur  (state_r),
    .data_byte  (s1_byte_r),
    .has_byte   (s1_has_r),
    .state_next (state_dec)
  );

  always_comb begin
    count_nxt = count_r;
    if (s1_has_r && count_r != COUNT_SAT) begin
      count_nxt = count_r + {{(COUNT_W-1){1'b0}}, 1'b1};
    end
  end

  always_comb begin
    if (state_dec.err || state_dec.pending != 2'd0) begin
      status_nxt = STATUS_NONCANON;
    end else if (count_nxt > {1'b0, max_len_r}) begin
      status_nxt = STATUS_TOO_LONG;
    end else begin
      status_nxt = STATUS_OK;
    end
  end

  always_comb begin
    state_nxt = state_dec;
    if (s1_last_r) begin
      state_nxt = '0;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
    if (!in_stall && in_valid) begin
      s1_byte_r <= in_data_byte;
      s1_has_r  <= in_has_byte;
      s1_last_r <= in_last;
    end
  end

  // text state and byte count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
      count_r <= '0;
    end else if (s1_adv) begin
      state_r <= state_nxt;
      count_r <= s1_last_r ? '0 : count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= '1;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  // verdict register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      status_r    <= STATUS_OK;
    end else if (out_free) begin
      out_valid_r <= s1_adv && s1_last_r;
      if (s1_adv && s1_last_r) begin
        status_r <= status_nxt;
      end
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = status_r;

  a_count_sat: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= COUNT_SAT)
    else $error("byte count past saturation");

  a_pending_le_lead: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pending <= state_r.lead_len)
    else $error("pending continuations exceed lead length");

  a_clear_after_end: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> count_r == '0 && state_r == '0)
    else $error("text state not cleared after last item");

  a_verdict_slot: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> out_valid_r)
    else $error("last item advanced without a verdict");

  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_last_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked verdict");

endmodule

@@ dv/utf8_verdict_checker.sv @@
// checker: predicts each text verdict of the utf-8 canonical text checker and compares it
`timescale 1ns / 1ps

module utf8_verdict_checker
  import utf8c_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic             in_stall,
  input  logic [7:0]       in_data_byte,
  input  logic             in_has_byte,
  input  logic             in_last,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [1:0]       out_status,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data,
  output int               mismatches,
  output int               outstanding,
  output int               verdicts_checked
);

  logic [LEN_W-1:0]   max_len;
  logic [1:0]         cont_left;
  logic [1:0]         lead_conts;
  logic [CP_W-1:0]    cp_acc;
  logic               bad_text;
  logic [COUNT_W-1:0] bytes_seen;
  utf8c_status_t      due_status[$];
  utf8c_status_t      oldest;

  task automatic clear_text();
    cont_left  = 2'd0;
    lead_conts = 2'd0;
    cp_acc     = '0;
    bad_text   = 1'b0;
    bytes_seen = '0;
  endtask

  task automatic absorb_item(input logic [7:0] b, input logic has, input logic last);
    utf8c_status_t verdict;
    if (has) begin
      if (bytes_seen != COUNT_SAT) bytes_seen = bytes_seen + COUNT_W'(1);
      if (!bad_text) begin
        if (cont_left == 2'd0) begin
          if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            cp_acc     = {{(CP_W-5){1'b0}}, b[4:0]};
            lead_conts = 2'd1;
            cont_left  = 2'd1;
          end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            cp_acc     = {{(CP_W-4){1'b0}}, b[3:0]};
            lead_conts = 2'd2;
            cont_left  = 2'd2;
          end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            cp_acc     = {{(CP_W-3){1'b0}}, b[2:0]};
            lead_conts = 2'd3;
            cont_left  = 2'd3;
          end else if (b[7]) begin
            bad_text = 1'b1;
          end
        end else if (b[7:6] != 2'b10) begin
          bad_text = 1'b1;
        end else begin
          cp_acc    = {cp_acc[CP_W-7:0], b[5:0]};
          cont_left = cont_left - 2'd1;
          // overlong, out of range, surrogate or combining mark
          if (cont_left == 2'd0 &&
              (cp_acc < CP_ASCII_END ||
               (cp_acc < CP_TWO_END && lead_conts >= 2'd2) ||
               (cp_acc < CP_THREE_END && lead_conts >= 2'd3) ||
               cp_acc > CP_MAX ||
               (cp_acc >= CP_SURR_LO && cp_acc <= CP_SURR_HI) ||
               (cp_acc >= CP_COMB_LO && cp_acc <= CP_COMB_HI))) begin
            bad_text = 1'b1;
          end
        end
      end
    end
    if (last) begin
      if (cont_left != 2'd0) bad_text = 1'b1;
      if (bad_text) begin
        verdict = STATUS_NONCANON;
      end else if (bytes_seen > {1'b0, max_len}) begin
        verdict = STATUS_TOO_LONG;
      end else begin
        verdict = STATUS_OK;
      end
      due_status.push_back(verdict);
      clear_text();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      max_len = '1;
      clear_text();
      due_status.delete();
      mismatches       = 0;
      verdicts_checked = 0;
    end else begin
      if (cfg_wr_en) max_len = cfg_wr_data;
      if (out_valid && !out_stall) begin
        if (due_status.size() == 0) begin
          $display("%0t: verdict %0d arrived with none expected", $time, out_status);
          mismatches++;
        end else begin
          oldest = due_status.pop_front();
          verdicts_checked++;
          if (out_status !== oldest) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, oldest, out_status);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) absorb_item(in_data_byte, in_has_byte, in_last);
    end
    outstanding = due_status.size();
  end

endmodule

@@ dv/tb_utf8_canonical_text_checker.sv @@
// testbench top: stimulus, flow control and final verdict for the utf-8 canonical text checker
`timescale 1ns / 1ps

module tb_utf8_canonical_text_checker;
  import utf8c_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 190;
  localparam int DRAIN_CYCLES = 4;
  localparam int END_CYCLES   = 8;

  logic             clk;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       in_data_byte = '0;
  logic             in_has_byte = 1'b0;
  logic             in_last = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       out_status;
  logic             cfg_wr_en = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;

  int mismatches;
  int outstanding;
  int verdicts_checked;
  int cycle_count = 0;
  int items_sent = 0;
  int texts_sent = 0;
  int limits_used = 1;
  int stall_left = 0;
  int rx_wait;
  int goal;
  bit tx_burst = 1'b0;
  bit rx_burst = 1'b0;

  logic [7:0]       text_bytes[$];
  logic [CP_W-1:0]  edge_points [0:13] = '{21'h80, 21'h7ff, 21'h800, 21'hffff, 21'h10000,
                                           21'h10ffff, 21'hd7ff, 21'hd800, 21'hdfff,
                                           21'he000, 21'h2ff, 21'h300, 21'h36f, 21'h370};
  logic [LEN_W-1:0] limit_steps [0:6] = '{32'd0, 32'd1, 32'd3, 32'd8, 32'd0,
                                          32'hfffffffe, 32'hffffffff};

  utf8_canonical_text_checker uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data_byte (in_data_byte),
    .in_has_byte  (in_has_byte),
    .in_last      (in_last),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_status   (out_status),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  utf8_verdict_checker u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_data_byte     (in_data_byte),
    .in_has_byte      (in_has_byte),
    .in_last          (in_last),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .verdicts_checked (verdicts_checked)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // receiver: random stall after each verdict, with runs of no stall
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      if ($urandom_range(0, 7) == 0) rx_burst = !rx_burst;
      rx_wait = rx_burst ? 0 : $urandom_range(0, 16);
      stall_left <= rx_wait;
      out_stall  <= (rx_wait != 0);
    end else if (out_stall) begin
      if (stall_left <= 1) out_stall <= 1'b0;
      stall_left <= stall_left - 1;
    end
  end

  task automatic drive_item(input logic [7:0] b, input logic has, input logic last);
    int gap;
    bit taken;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    repeat (gap) begin
      in_valid     <= 1'b0;
      in_data_byte <= 8'($urandom);
      in_has_byte  <= 1'($urandom);
      in_last      <= 1'($urandom);
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data_byte <= b;
    in_has_byte  <= has;
    in_last      <= last;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    if (has || last) items_sent++;
  endtask

  task automatic send_text(input bit end_on_byte);
    int i;
    for (i = 0; i < text_bytes.size(); i++) begin
      if ($urandom_range(0, 19) == 0) drive_item(8'($urandom), 1'b0, 1'b0);
      drive_item(text_bytes[i], 1'b1, end_on_byte && (i == text_bytes.size() - 1));
    end
    if (!end_on_byte || text_bytes.size() == 0) drive_item(8'($urandom), 1'b0, 1'b1);
    texts_sent++;
    if ($urandom_range(0, 7) == 0) tx_burst = !tx_burst;
  endtask

  task automatic add_code_point(input logic [CP_W-1:0] cp);
    if (cp < CP_ASCII_END) begin
      text_bytes.push_back(cp[7:0]);
    end else if (cp < CP_TWO_END) begin
      text_bytes.push_back({3'b110, cp[10:6]});
      text_bytes.push_back({2'b10, cp[5:0]});
    end else if (cp < CP_THREE_END) begin
      text_bytes.push_back({4'b1110, cp[15:12]});
      text_bytes.push_back({2'b10, cp[11:6]});
      text_bytes.push_back({2'b10, cp[5:0]});
    end else begin
      text_bytes.push_back({5'b11110, cp[20:18]});
      text_bytes.push_back({2'b10, cp[17:12]});
      text_bytes.push_back({2'b10, cp[11:6]});
      text_bytes.push_back({2'b10, cp[5:0]});
    end
  endtask

  // mostly well-formed characters, some broken sequences and raw noise
  task automatic random_text();
    int nchar;
    int kind;
    text_bytes.delete();
    nchar = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 20) : $urandom_range(0, 6);
    repeat (nchar) begin
      kind = $urandom_range(0, 99);
      if (kind < 35) begin
        add_code_point(CP_W'($urandom_range(0, 'h7f)));
      end else if (kind < 55) begin
        add_code_point(CP_W'($urandom_range('h80, 'h7ff)));
      end else if (kind < 72) begin
        add_code_point(CP_W'($urandom_range('h800, 'hffff)));
      end else if (kind < 84) begin
        add_code_point(CP_W'($urandom_range('h10000, 'h10ffff)));
      end else if (kind < 90) begin
        add_code_point(edge_points[$urandom_range(0, 13)]);
      end else if (kind < 95) begin
        text_bytes.push_back(8'($urandom_range('h80, 'hff)));
        repeat ($urandom_range(0, 3)) text_bytes.push_back(8'($urandom_range('h80, 'hbf)));
      end else begin
        text_bytes.push_back(8'($urandom));
      end
    end
    // cut-off sequence at the end
    if (text_bytes.size() > 0 && $urandom_range(0, 19) == 0) void'(text_bytes.pop_back());
    send_text($urandom_range(0, 1));
  endtask

  task automatic wait_idle(input int extra);
    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (extra) @(posedge clk);
  endtask

  initial begin
    int i;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty text
    text_bytes.delete();
    send_text(1'b0);
    text_bytes = '{8'h00, 8'h7f};
    send_text(1'b1);
    text_bytes = '{8'hc2, 8'h80};
    send_text(1'b1);
    // invalid leads
    text_bytes = '{8'hc1};
    send_text(1'b1);
    text_bytes = '{8'hff};
    send_text(1'b1);
    // overlong three-byte form
    text_bytes = '{8'he0, 8'h9f, 8'hbf};
    send_text(1'b1);
    // surrogate
    text_bytes = '{8'hed, 8'ha0, 8'h80};
    send_text(1'b1);
    // combining mark
    text_bytes = '{8'hcc, 8'h80};
    send_text(1'b1);
    // above the largest code point
    text_bytes = '{8'hf4, 8'h90, 8'h80, 8'h80};
    send_text(1'b1);
    text_bytes = '{8'hf4, 8'h8f, 8'hbf, 8'hbf};
    send_text(1'b1);
    // bad continuation
    text_bytes = '{8'hc3, 8'h41};
    send_text(1'b1);
    drive_item(8'ha5, 1'b0, 1'b0);
    // sequence cut off by an end-only item
    text_bytes = '{8'he2, 8'h82};
    send_text(1'b0);

    goal = items_sent + PHASE_ITEMS;
    while (items_sent < goal) random_text();

    for (i = 0; i < 7; i++) begin
      wait_idle(DRAIN_CYCLES);
      cfg_wr_en   <= 1'b1;
      cfg_wr_data <= (i == 4) ? LEN_W'($urandom_range(0, 30)) : limit_steps[i];
      @(posedge clk);
      cfg_wr_en <= 1'b0;
      limits_used++;
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) random_text();
    end

    wait_idle(END_CYCLES);
    $display("sent %0d items in %0d texts under %0d length limits", items_sent, texts_sent,
             limits_used);
    $display("checked %0d verdicts, %0d mismatches", verdicts_checked, mismatches);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
